FILE: rtl/pth_pkg.sv
package pth_pkg;

  localparam int PIXEL_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int INV_BITS   = 16;
  localparam int GRID_BITS  = 8;
  localparam int CUBE_W     = 8;

  localparam int TOT_FRAC = FRAC_BITS + INV_BITS;
  localparam int OFF_W    = PIXEL_BITS + 1;
  localparam int NQ_W     = PIXEL_BITS + FRAC_BITS + 2;
  localparam int MB_W     = (FRAC_BITS > INV_BITS) ? FRAC_BITS : INV_BITS;
  localparam int PROD_W   = NQ_W + MB_W + 1;
  localparam int FQ_W     = NQ_W + INV_BITS;
  localparam int FS_W     = FQ_W + 1;
  localparam int RI_W     = FS_W + 1 - TOT_FRAC;
  localparam int CW       = RI_W + 2;
  localparam int ERR_W    = TOT_FRAC;
  localparam int LIM_W    = GRID_BITS - 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INV_RADIUS = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE  = CFG_IDX_W'(3);

  localparam logic [INV_BITS-1:0]  INV_RADIUS_RST = INV_BITS'(2048);
  localparam logic [GRID_BITS-1:0] GRID_SIZE_RST  = GRID_BITS'(11);

  // Round a Q32 constant to nearest in Q(FRAC_BITS).
  function automatic logic [FRAC_BITS-1:0] to_frac(input logic [63:0] q32);
    logic [63:0] sum;
    sum = q32 + (64'd1 << (31 - FRAC_BITS));
    return FRAC_BITS'(sum >> (32 - FRAC_BITS));
  endfunction

  localparam logic [FRAC_BITS-1:0] K_SQRT3_3   = to_frac(64'd2479700524);
  localparam logic [FRAC_BITS-1:0] K_THIRD     = to_frac(64'd1431655765);
  localparam logic [FRAC_BITS-1:0] K_TWO_THIRD = to_frac(64'd2863311531);

endpackage

FILE: rtl/pth_in_if.sv
interface pth_in_if import pth_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_x;
  logic [PIXEL_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

FILE: rtl/pth_out_if.sv
interface pth_out_if import pth_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CUBE_W-1:0] cube_q;
  logic signed [CUBE_W-1:0] cube_r;
  logic signed [CUBE_W-1:0] cube_s;

  modport source (output valid, output cube_q, output cube_r, output cube_s, input ready);
  modport sink   (input valid, input cube_q, input cube_r, input cube_s, output ready);
endinterface

FILE: rtl/pth_cfg_if.sv
interface pth_cfg_if import pth_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/pixel_to_hex_clamped.sv
// The clamp walk takes no steps inside the grid, else the hex distance of the
// rounded tile minus the limit plus one.
// The input is ready only while idle, so one transaction is finished before the
// next is accepted; all multiplies go through the single shared multiplier.
// Reset (rst_n low, synchronous): sequencer idle, no result pending,
// center 0/0, inv_radius 2048, grid_size 11.
module pixel_to_hex_clamped import pth_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  pth_in_if.sink       in_ch,
  pth_out_if.source    out_ch,
  pth_cfg_if.sink      cfg_ch
);

  // Sequencer codes
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_M0   = 4'd1;  // acc = K(sqrt3/3) * x
  localparam logic [3:0] ST_M1   = 4'd2;  // acc -= K(1/3) * y  -> nq
  localparam logic [3:0] ST_M2   = 4'd3;  // nr = K(2/3) * y
  localparam logic [3:0] ST_M3   = 4'd4;  // fq = nq * inv_radius
  localparam logic [3:0] ST_M4   = 4'd5;  // fr = nr * inv_radius
  localparam logic [3:0] ST_R0   = 4'd6;  // round fq, form fs
  localparam logic [3:0] ST_R1   = 4'd7;  // round fr
  localparam logic [3:0] ST_R2   = 4'd8;  // round fs
  localparam logic [3:0] ST_FIX  = 4'd9;  // re-derive worst component, latch limit
  localparam logic [3:0] ST_WALK = 4'd10; // one clamp step per cycle
  localparam logic [3:0] ST_DONE = 4'd11; // hand result to output register

  // Configuration registers
  logic [PIXEL_BITS-1:0] center_x_r;
  logic [PIXEL_BITS-1:0] center_y_r;
  logic [INV_BITS-1:0]   inv_radius_r;
  logic [GRID_BITS-1:0]  grid_size_r;

  // Sequencer and datapath registers
  logic [3:0]               state_r, state_nxt;
  logic signed [OFF_W-1:0]  x_r, x_nxt;
  logic signed [OFF_W-1:0]  y_r, y_nxt;
  logic signed [NQ_W-1:0]   acc_r, acc_nxt;
  logic signed [NQ_W-1:0]   nr_r, nr_nxt;
  logic signed [FQ_W-1:0]   fq_r, fq_nxt;
  logic signed [FQ_W-1:0]   fr_r, fr_nxt;
  logic signed [FS_W-1:0]   fs_r, fs_nxt;
  logic signed [CW-1:0]     q_r, q_nxt;
  logic signed [CW-1:0]     r_r, r_nxt;
  logic signed [CW-1:0]     s_r, s_nxt;
  logic [ERR_W-1:0]         dq_r, dq_nxt;
  logic [ERR_W-1:0]         dr_r, dr_nxt;
  logic [ERR_W-1:0]         ds_r, ds_nxt;
  logic [LIM_W-1:0]         lim_r, lim_nxt;

  // Output register
  logic                     out_valid_r, out_valid_nxt;
  logic signed [CUBE_W-1:0] out_q_r, out_q_nxt;
  logic signed [CUBE_W-1:0] out_r_r, out_r_nxt;
  logic signed [CUBE_W-1:0] out_s_r, out_s_nxt;

  logic in_acc;
  logic out_load;

  // Shared multiplier: signed A times unsigned B
  logic signed [NQ_W-1:0]   mul_a;
  logic [MB_W-1:0]          mul_b;
  logic signed [PROD_W-1:0] mul_p;

  // Shared rounding unit: half away from zero, with absolute error
  logic signed [FS_W-1:0] rnd_in;
  logic                   rnd_neg;
  logic [FS_W-1:0]        rnd_mag;
  logic [FS_W:0]          rnd_sum;
  logic [RI_W-1:0]        rnd_ri;
  logic [FS_W:0]          rnd_back;
  logic [ERR_W-1:0]       rnd_err;
  logic signed [CW-1:0]   rnd_val;

  // Clamp walk
  logic [CW-1:0]    mq, mr, ms;
  logic [CW+1:0]    mag_sum;
  logic [CW:0]      hex_dist;
  logic             walk_step;
  logic [LIM_W-1:0] lim_calc;

  function automatic logic signed [CW-1:0] toward_zero(input logic signed [CW-1:0] v);
    return v[CW-1] ? v + CW'(1) : v - CW'(1);
  endfunction

  assign in_acc         = in_ch.valid && in_ch.ready;
  assign in_ch.ready    = (state_r == ST_IDLE);
  assign cfg_ch.ready   = 1'b1;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.cube_q  = out_q_r;
  assign out_ch.cube_r  = out_r_r;
  assign out_ch.cube_s  = out_s_r;

  // Configuration writes; the user must send these only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r   <= '0;
      center_y_r   <= '0;
      inv_radius_r <= INV_RADIUS_RST;
      grid_size_r  <= GRID_SIZE_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        REG_CENTER_X:   center_x_r   <= cfg_ch.data[PIXEL_BITS-1:0];
        REG_CENTER_Y:   center_y_r   <= cfg_ch.data[PIXEL_BITS-1:0];
        REG_INV_RADIUS: inv_radius_r <= cfg_ch.data[INV_BITS-1:0];
        REG_GRID_SIZE:  grid_size_r  <= cfg_ch.data[GRID_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = NQ_W'(x_r);
    mul_b = MB_W'(K_SQRT3_3);
    unique case (state_r)
      ST_M1: begin
        mul_a = NQ_W'(y_r);
        mul_b = MB_W'(K_THIRD);
      end
      ST_M2: begin
        mul_a = NQ_W'(y_r);
        mul_b = MB_W'(K_TWO_THIRD);
      end
      ST_M3: begin
        mul_a = acc_r;
        mul_b = MB_W'(inv_radius_r);
      end
      ST_M4: begin
        mul_a = nr_r;
        mul_b = MB_W'(inv_radius_r);
      end
      default: ;
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_b}));

  // Rounding unit input: fq, then fr, then fs
  always_comb begin
    unique case (state_r)
      ST_R1:   rnd_in = FS_W'(fr_r);
      ST_R2:   rnd_in = fs_r;
      default: rnd_in = FS_W'(fq_r);
    endcase
  end

  assign rnd_neg  = rnd_in[FS_W-1];
  assign rnd_mag  = rnd_neg ? FS_W'(-rnd_in) : FS_W'(rnd_in);
  assign rnd_sum  = {1'b0, rnd_mag} + ((FS_W+1)'(1) << (TOT_FRAC - 1));
  assign rnd_ri   = rnd_sum[FS_W:TOT_FRAC];
  assign rnd_back = {rnd_ri, {TOT_FRAC{1'b0}}};
  assign rnd_err  = (rnd_back >= {1'b0, rnd_mag}) ? ERR_W'(rnd_back - {1'b0, rnd_mag})
                                                  : ERR_W'({1'b0, rnd_mag} - rnd_back);
  assign rnd_val  = rnd_neg ? -$signed(CW'(rnd_ri)) : $signed(CW'(rnd_ri));

  // Distance limit: (grid_size-1)/2 - 1, never below one
  assign lim_calc = (grid_size_r < GRID_BITS'(5)) ? LIM_W'(1)
                    : LIM_W'((grid_size_r - GRID_BITS'(1)) >> 1) - LIM_W'(1);

  // Clamp walk: magnitudes and hex distance of the current coordinate
  assign mq        = q_r[CW-1] ? CW'(-q_r) : CW'(q_r);
  assign mr        = r_r[CW-1] ? CW'(-r_r) : CW'(r_r);
  assign ms        = s_r[CW-1] ? CW'(-s_r) : CW'(s_r);
  assign mag_sum   = (CW+2)'(mq) + (CW+2)'(mr) + (CW+2)'(ms);
  assign hex_dist  = mag_sum[CW+1:1];
  assign walk_step = (hex_dist >= (CW+1)'(lim_r));

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    acc_nxt   = acc_r;
    nr_nxt    = nr_r;
    fq_nxt    = fq_r;
    fr_nxt    = fr_r;
    fs_nxt    = fs_r;
    q_nxt     = q_r;
    r_nxt     = r_r;
    s_nxt     = s_r;
    dq_nxt    = dq_r;
    dr_nxt    = dr_r;
    ds_nxt    = ds_r;
    lim_nxt   = lim_r;
    out_q_nxt = out_q_r;
    out_r_nxt = out_r_r;
    out_s_nxt = out_s_r;

    unique case (state_r)
      ST_IDLE: begin
        // Latch centered offsets on the input transaction
        if (in_acc) begin
          x_nxt     = $signed(OFF_W'({1'b0, in_ch.pixel_x})) - $signed(OFF_W'({1'b0, center_x_r}));
          y_nxt     = $signed(OFF_W'({1'b0, in_ch.pixel_y})) - $signed(OFF_W'({1'b0, center_y_r}));
          state_nxt = ST_M0;
        end
      end
      ST_M0: begin
        acc_nxt   = mul_p[NQ_W-1:0];
        state_nxt = ST_M1;
      end
      ST_M1: begin
        acc_nxt   = acc_r - mul_p[NQ_W-1:0];
        state_nxt = ST_M2;
      end
      ST_M2: begin
        nr_nxt    = mul_p[NQ_W-1:0];
        state_nxt = ST_M3;
      end
      ST_M3: begin
        fq_nxt    = mul_p[FQ_W-1:0];
        state_nxt = ST_M4;
      end
      ST_M4: begin
        fr_nxt    = mul_p[FQ_W-1:0];
        state_nxt = ST_R0;
      end
      ST_R0: begin
        q_nxt     = rnd_val;
        dq_nxt    = rnd_err;
        fs_nxt    = -FS_W'(fq_r) - FS_W'(fr_r);
        state_nxt = ST_R1;
      end
      ST_R1: begin
        r_nxt     = rnd_val;
        dr_nxt    = rnd_err;
        state_nxt = ST_R2;
      end
      ST_R2: begin
        s_nxt     = rnd_val;
        ds_nxt    = rnd_err;
        state_nxt = ST_FIX;
      end
      ST_FIX: begin
        // Rebuild the component that rounded worst so that q + r + s = 0
        priority if (dq_r > dr_r && dq_r > ds_r) begin
          q_nxt = -r_r - s_r;
        end else if (dr_r > ds_r) begin
          r_nxt = -q_r - s_r;
        end else begin
          s_nxt = -q_r - r_r;
        end
        lim_nxt   = lim_calc;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        // Step the largest and next largest magnitudes toward zero
        if (walk_step) begin
          priority if (mq > mr && mq > ms) begin
            q_nxt = toward_zero(q_r);
            if (mr > ms) r_nxt = toward_zero(r_r);
            else         s_nxt = toward_zero(s_r);
          end else if (mr > ms) begin
            r_nxt = toward_zero(r_r);
            if (mq > ms) q_nxt = toward_zero(q_r);
            else         s_nxt = toward_zero(s_r);
          end else begin
            s_nxt = toward_zero(s_r);
            if (mq > mr) q_nxt = toward_zero(q_r);
            else         r_nxt = toward_zero(r_r);
          end
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (out_load) begin
          out_q_nxt = q_r[CUBE_W-1:0];
          out_r_nxt = r_r[CUBE_W-1:0];
          out_s_nxt = s_r[CUBE_W-1:0];
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load)          out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    acc_r   <= acc_nxt;
    nr_r    <= nr_nxt;
    fq_r    <= fq_nxt;
    fr_r    <= fr_nxt;
    fs_r    <= fs_nxt;
    q_r     <= q_nxt;
    r_r     <= r_nxt;
    s_r     <= s_nxt;
    dq_r    <= dq_nxt;
    dr_r    <= dr_nxt;
    ds_r    <= ds_nxt;
    lim_r   <= lim_nxt;
    out_q_r <= out_q_nxt;
    out_r_r <= out_r_nxt;
    out_s_r <= out_s_nxt;
  end

  // An input transaction always starts the multiply sequence
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_M0))
    else $error("sequencer did not start after input transaction");

  // Each clamp step keeps the cube invariant
  a_walk_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> ((q_r + r_r + s_r) == CW'(0)))
    else $error("cube invariant broken during clamp walk");

  // A finished walk leaves every magnitude below the limit
  a_walk_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> ((CW+1)'(mq) < (CW+1)'(lim_r) && (CW+1)'(mr) < (CW+1)'(lim_r)
                              && (CW+1)'(ms) < (CW+1)'(lim_r)))
    else $error("clamp walk ended outside the limit");

  // Presented results sum to zero
  a_out_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_q_r + out_r_r + out_s_r) == CUBE_W'(0)))
    else $error("result does not satisfy q + r + s = 0");

endmodule

FILE: verif/tb_pixel_to_hex_clamped.sv
module tb_pixel_to_hex_clamped import pth_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Hex basis constants, rounded to nearest from Q32 down to Q16.
  localparam longint K_AXIAL_Q = (64'd2479700524 + 64'd32768) >> 16;  // sqrt(3)/3
  localparam longint K_ONE_3RD = (64'd1431655765 + 64'd32768) >> 16;  // 1/3
  localparam longint K_TWO_3RD = (64'd2863311531 + 64'd32768) >> 16;  // 2/3
  localparam int     FQ_SHIFT  = 32;       // fraction bits of fq, fr and fs
  localparam longint CYCLE_LIMIT = 5000000;
  localparam int     TAIL_CYCLES = 64;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] x;
    logic [PIXEL_BITS-1:0] y;
  } pixel_t;

  typedef struct packed {
    logic signed [CUBE_W-1:0] q;
    logic signed [CUBE_W-1:0] r;
    logic signed [CUBE_W-1:0] s;
  } cube_t;

  logic clk;
  logic rst_n;

  pth_in_if  in_ch ();
  pth_out_if out_ch ();
  pth_cfg_if cfg_ch ();

  pixel_to_hex_clamped uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Shadow copy of the register file, updated on every accepted config write.
  logic [PIXEL_BITS-1:0] ctr_x   = '0;
  logic [PIXEL_BITS-1:0] ctr_y   = '0;
  logic [15:0]           inv_rad = 16'd2048;
  logic [7:0]            gsize   = 8'd11;

  pixel_t pend_q[$];    // pixels waiting to be offered on the input channel
  cube_t  cube_q[$];    // predicted tile coordinates, oldest first
  int     idle_pct;
  int     err_cnt;
  longint cycle_cnt;

  // ---------------------------------------------------------------------------
  // Tile predictor
  // ---------------------------------------------------------------------------

  function automatic longint mag_of(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Move one unit toward zero.
  function automatic longint step_in(input longint v);
    return (v < 0) ? v + 1 : v - 1;
  endfunction

  // Round half away from zero; err receives the distance to the rounded value.
  function automatic longint round_half_away(input longint v, output longint unsigned err);
    longint unsigned m, ri, back;
    m    = (v < 0) ? longint'(-v) : longint'(v);
    ri   = (m + (64'd1 << (FQ_SHIFT - 1))) >> FQ_SHIFT;
    back = ri << FQ_SHIFT;
    err  = (back >= m) ? back - m : m - back;
    return (v < 0) ? -longint'(ri) : longint'(ri);
  endfunction

  function automatic cube_t predict_cube(input logic [PIXEL_BITS-1:0] px,
                                         input logic [PIXEL_BITS-1:0] py);
    longint dx, dy, nq, nr, fq, fr, fs, cq, cr, cs, lim;
    longint unsigned eq, er, es;
    cube_t res;
    dx = longint'(px) - longint'(ctr_x);
    dy = longint'(py) - longint'(ctr_y);
    nq = K_AXIAL_Q * dx - K_ONE_3RD * dy;
    nr = K_TWO_3RD * dy;
    fq = nq * longint'(inv_rad);
    fr = nr * longint'(inv_rad);
    fs = -fq - fr;
    cq = round_half_away(fq, eq);
    cr = round_half_away(fr, er);
    cs = round_half_away(fs, es);

    // Re-derive the worst-rounded component; ties fall through to r, then s.
    if (eq > er && eq > es) cq = -cr - cs;
    else if (er > es)       cr = -cq - cs;
    else                    cs = -cq - cr;

    lim = (longint'(gsize) - 1) / 2 - 1;
    if (lim < 1) lim = 1;

    // Pull the tile back toward the origin one ring per step.
    while ((mag_of(cq) + mag_of(cr) + mag_of(cs)) / 2 >= lim) begin
      if (mag_of(cq) > mag_of(cr) && mag_of(cq) > mag_of(cs)) begin
        cq = step_in(cq);
        if (mag_of(cr) > mag_of(cs)) cr = step_in(cr);
        else cs = step_in(cs);
      end else if (mag_of(cr) > mag_of(cs)) begin
        cr = step_in(cr);
        if (mag_of(cq) > mag_of(cs)) cq = step_in(cq);
        else cs = step_in(cs);
      end else begin
        cs = step_in(cs);
        if (mag_of(cq) > mag_of(cr)) cq = step_in(cq);
        else cr = step_in(cr);
      end
    end

    res.q = cq[CUBE_W-1:0];
    res.r = cr[CUBE_W-1:0];
    res.s = cs[CUBE_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, watchdog
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort the run if the block stops answering.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel driver: offer the head of pend_q, predict on every accepted transaction
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        cube_q = {cube_q, predict_cube(pend_q[0].x, pend_q[0].y)};
        void'(pend_q.pop_front());
      end
      // Hold a pending transaction until it is taken; otherwise offer the next
      // pixel unless this cycle is picked as a gap.
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (pend_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_ch.valid   <= 1'b1;
          in_ch.pixel_x <= pend_q[0].x;
          in_ch.pixel_y <= pend_q[0].y;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: stall at random, compare each accepted transaction
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_tiles
    cube_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (cube_q.size() == 0) begin
          $display("%0t: result with nothing expected, got q=%0d r=%0d s=%0d",
                   $time, out_ch.cube_q, out_ch.cube_r, out_ch.cube_s);
          err_cnt++;
        end else begin
          want = cube_q.pop_front();
          if (out_ch.cube_q !== want.q) begin
            $display("%0t: cube_q mismatch, expected %0d, got %0d",
                     $time, want.q, out_ch.cube_q);
            err_cnt++;
          end
          if (out_ch.cube_r !== want.r) begin
            $display("%0t: cube_r mismatch, expected %0d, got %0d",
                     $time, want.r, out_ch.cube_r);
            err_cnt++;
          end
          if (out_ch.cube_s !== want.s) begin
            $display("%0t: cube_s mismatch, expected %0d, got %0d",
                     $time, want.s, out_ch.cube_s);
            err_cnt++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Call on a clock-edge step; leaves cfg valid high so writes can run back to back.
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_CENTER_X:   ctr_x   = val[PIXEL_BITS-1:0];
      REG_CENTER_Y:   ctr_y   = val[PIXEL_BITS-1:0];
      REG_INV_RADIUS: inv_rad = val[15:0];
      REG_GRID_SIZE:  gsize   = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] cx, input logic [15:0] cy,
                            input logic [15:0] inv, input logic [15:0] gs);
    reg_write(REG_CENTER_X, cx);
    reg_write(REG_CENTER_Y, cy);
    reg_write(REG_INV_RADIUS, inv);
    reg_write(REG_GRID_SIZE, gs);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic push_pixel(input int px, input int py);
    pixel_t p;
    p.x = px[PIXEL_BITS-1:0];
    p.y = py[PIXEL_BITS-1:0];
    pend_q = {pend_q, p};
  endtask

  // Pixels spread over the whole screen, or within span of the grid centre.
  task automatic queue_random_pixels(input int n, input int span);
    int px, py;
    for (int i = 0; i < n; i++) begin
      if (span >= 4096) begin
        px = $urandom_range(4095);
        py = $urandom_range(4095);
      end else begin
        px = int'(ctr_x) + int'($urandom_range(2 * span)) - span;
        py = int'(ctr_y) + int'($urandom_range(2 * span)) - span;
        if (px < 0) px = 0;
        if (px > 4095) px = 4095;
        if (py < 0) py = 0;
        if (py > 4095) py = 4095;
      end
      push_pixel(px, py);
    end
  endtask

  // Block until every queued pixel has been answered; returns on a clock edge.
  task automatic wait_quiet();
    while (pend_q.size() != 0 || cube_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [15:0] cx, cy, inv, gs;
    int          span;

    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.pixel_x  = '0;
    in_ch.pixel_y  = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_CENTER_X;
    cfg_ch.data    = '0;
    idle_pct       = 9;
    err_cnt        = 0;
    cycle_cnt      = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset register values: screen corners and an interior point.
    push_pixel(0, 0);
    push_pixel(4095, 0);
    push_pixel(0, 4095);
    push_pixel(4095, 4095);
    push_pixel(2048, 1024);
    queue_random_pixels(30, 4096);
    wait_quiet();

    // Exact half on q (offset -26, +2166 at reciprocal radius 1/2), then the centre pixel
    // itself where all three rounding errors tie at zero; widest grid.
    set_config(16'd2048, 16'd0, 16'd32768, 16'd255);
    push_pixel(2022, 2166);
    push_pixel(2048, 0);
    wait_quiet();

    // Smallest legal grid at the largest reciprocal radius: the far corner walks
    // thousands of steps all the way back to the origin.
    set_config(16'd4095, 16'd4095, 16'd65535, 16'd5);
    push_pixel(4095, 4095);
    push_pixel(4094, 4095);
    push_pixel(0, 0);
    push_pixel(4095, 4094);
    wait_quiet();

    // Grid below the legal minimum clamps to the origin; smallest radius step.
    set_config(16'd0, 16'd0, 16'd1, 16'd0);
    push_pixel(4095, 4095);
    push_pixel(0, 0);
    wait_quiet();

    // Zero reciprocal radius collapses everything to the origin; junk in the
    // unused upper data bits must be dropped.
    set_config(16'hF7FF, 16'hA000, 16'd0, 16'hFFC8);
    push_pixel(4095, 0);
    push_pixel(0, 4095);
    wait_quiet();

    // Random phases, each with a fresh register setting.
    for (int ph = 0; ph < 13; ph++) begin
      // Run a stretch of phases with both sides streaming flat out.
      idle_pct = (ph >= 4 && ph <= 7) ? 0 : 9;
      cx = 16'($urandom);
      cy = 16'($urandom);
      if ($urandom_range(3) == 0) gs = {8'($urandom), 8'($urandom_range(12))};
      else gs = {8'($urandom), 8'($urandom_range(255))};
      if ($urandom_range(7) == 0) begin
        // Large reciprocal radius: keep pixels close so the walk stays short.
        inv  = 16'($urandom_range(65535));
        span = 64;
      end else begin
        inv  = 16'($urandom_range(1, 4096));
        span = ($urandom_range(2) == 0) ? 200 : 4096;
      end
      set_config(cx, cy, inv, gs);
      queue_random_pixels(50, span);
      wait_quiet();
    end

    // Let any stray result surface before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pth_pkg.sv
rtl/pth_in_if.sv
rtl/pth_out_if.sv
rtl/pth_cfg_if.sv
rtl/pixel_to_hex_clamped.sv
verif/tb_pixel_to_hex_clamped.sv
